### src/brbs_pkg.sv
// ============================================================================
// brbs_pkg - shared definitions for the byte ring buffer with search
// Operation codes, storage geometry and the window control bundle.
// ============================================================================
`default_nettype none

package brbs_pkg;

    localparam int BYTE_W   = 8;
    localparam int FUNC_W   = 3;
    localparam int PLEN_W   = 4;
    localparam int ADDR_W   = 8;
    localparam int SLOTS    = 256;
    localparam int MAX_PAT  = 8;
    localparam int PAT_W    = MAX_PAT * BYTE_W;
    localparam int SEEN_W   = 3;

    // operation codes carried on the func field
    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_BFWD = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BBWD = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PFWD = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PBWD = 3'd5;

    // control from the scan sequencer to the match window
    typedef struct packed {
        logic clear;   // a new request was accepted: forget history
        logic shift;   // a byte from the memory is valid this cycle
    } win_ctl_t;

endpackage

`default_nettype wire

### src/brbs_window.sv
// ============================================================================
// brbs_window - sliding match window
// Keeps the last bytes read by a search and compares them with the
// pre-reversed pattern as each new byte arrives.
// ============================================================================
`default_nettype none

module brbs_window (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire brbs_pkg::win_ctl_t            ctl,
    input  wire logic [brbs_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic [brbs_pkg::PAT_W-1:0]    rpat,
    input  wire logic [brbs_pkg::PLEN_W-1:0]   plen,
    output logic                               hit
);

    logic [brbs_pkg::BYTE_W-1:0] hist_reg [brbs_pkg::MAX_PAT-1];
    logic [brbs_pkg::SEEN_W-1:0] seen_reg;
    logic [brbs_pkg::SEEN_W-1:0] seen_next;
    logic [brbs_pkg::BYTE_W-1:0] win [brbs_pkg::MAX_PAT];
    logic                        bytes_eq;

    // newest byte first, then history
    always_comb begin
        win[0] = byte_in;
        for (int m = 1; m < brbs_pkg::MAX_PAT; m++) begin
            win[m] = hist_reg[m-1];
        end
    end

    always_comb begin
        bytes_eq = 1'b1;
        for (int k = 0; k < brbs_pkg::MAX_PAT; k++) begin
            if (plen > brbs_pkg::PLEN_W'(k)) begin
                if (win[k] != rpat[k*brbs_pkg::BYTE_W +: brbs_pkg::BYTE_W]) begin
                    bytes_eq = 1'b0;
                end
            end
        end
        hit = ctl.shift && bytes_eq && ({1'b0, seen_reg} >= (plen - 4'd1));
    end

    // saturate: only plen-1 previous bytes ever matter
    always_comb begin
        seen_next = seen_reg;
        if (ctl.clear) begin
            seen_next = '0;
        end else if (ctl.shift && (seen_reg != '1)) begin
            seen_next = seen_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            hist_reg[0] <= byte_in;
            for (int m = 1; m < brbs_pkg::MAX_PAT - 1; m++) begin
                hist_reg[m] <= hist_reg[m-1];
            end
        end
    end

endmodule

`default_nettype wire

### src/byte_ring_buffer_with_search.sv
// Push, pop, unused codes, and searches on an empty ring or of zero length: result
//   registered in the cycle after acceptance; a new request is taken every cycle
//   while results are drained. Other searches read at most the fill count of bytes,
//   one per cycle through the single read port, until the first hit or the last.
// Reset: indices and fill count cleared, capacity set to 255; the byte store
//   keeps its contents and gets no clearing pass.
// ============================================================================
// byte_ring_buffer_with_search - byte FIFO ring with byte and pattern search
// Ring of capacity+1 slots in one synchronous memory, with forward/backward
// search of a byte or a pattern of up to eight bytes.
// ============================================================================
`default_nettype none

module byte_ring_buffer_with_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration: capacity register, write clears the buffer
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,

    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [63:0] s_pattern,
    input  wire logic [3:0]  s_pattern_len,

    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ok,
    output logic [7:0]       m_data_out,
    output logic [7:0]       m_match_offset,
    output logic [7:0]       m_fill_count,
    output logic             m_is_empty,
    output logic             m_is_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam int AW = brbs_pkg::ADDR_W;
    localparam int BW = brbs_pkg::BYTE_W;
    localparam int PW = brbs_pkg::PLEN_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic          state_reg,    state_next;
    logic [BW-1:0] cap_reg,      cap_next;      // usable capacity = ring-1
    logic [AW-1:0] old_reg,      old_next;      // oldest byte slot
    logic [AW-1:0] nf_reg,       nf_next;       // next free slot
    logic [AW-1:0] cnt_reg,      cnt_next;      // bytes held

    // scan sequencer
    logic [AW-1:0] scan_addr_reg, scan_addr_next;
    logic [AW-1:0] scan_off_reg,  scan_off_next;
    logic [AW-1:0] left_reg,      left_next;    // reads still to issue
    logic          fwd_reg,       fwd_next;
    logic [PW-1:0] plen_reg,      plen_next;
    logic [brbs_pkg::PAT_W-1:0] rpat_reg, rpat_next;

    // read pipeline: tags for the byte sitting in mem_rd_reg
    logic          rd_vld_reg,   rd_vld_next;
    logic [AW-1:0] rd_off_reg,   rd_off_next;
    logic          rd_last_reg,  rd_last_next;

    // output register
    logic          m_valid_reg,  m_valid_next;
    logic          ok_reg,       ok_next;
    logic          pop_reg,      pop_next;
    logic [AW-1:0] moff_reg,     moff_next;
    logic [AW-1:0] fill_reg,     fill_next;
    logic          empty_reg,    empty_next;
    logic          full_reg,     full_next;

    // byte store
    logic [BW-1:0] mem [brbs_pkg::SLOTS];
    logic [BW-1:0] mem_rd_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] rd_addr;

    // request decode
    logic          acc;
    logic          do_push;
    logic          do_pop;
    logic          do_search;
    logic          is_byte_op;
    logic          search_fwd;
    logic [PW-1:0] plen_sat;
    logic [PW-1:0] plen_eff;
    logic [brbs_pkg::PAT_W-1:0] src_pat;
    logic [brbs_pkg::PAT_W-1:0] rpat_in;

    brbs_pkg::win_ctl_t win_ctl;
    logic               win_hit;

    // ------------------------------------------------------------------
    // Handshake: take a request when idle and the output slot frees up
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign acc     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Decode the operation
    // ------------------------------------------------------------------
    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_search  = 1'b0;
        is_byte_op = 1'b0;
        search_fwd = 1'b0;
        unique case (s_func) inside
            brbs_pkg::FN_PUSH: begin
                do_push = 1'b1;
            end
            brbs_pkg::FN_POP: begin
                do_pop = 1'b1;
            end
            brbs_pkg::FN_BFWD, brbs_pkg::FN_BBWD: begin
                do_search  = 1'b1;
                is_byte_op = 1'b1;
                search_fwd = (s_func == brbs_pkg::FN_BFWD);
            end
            brbs_pkg::FN_PFWD, brbs_pkg::FN_PBWD: begin
                do_search  = 1'b1;
                search_fwd = (s_func == brbs_pkg::FN_PFWD);
            end
            default: begin
                // unused codes: status only
            end
        endcase
    end

    // Clamp pattern length; a byte search is a one-byte pattern.
    always_comb begin
        plen_sat = (s_pattern_len > PW'(brbs_pkg::MAX_PAT)) ?
                   PW'(brbs_pkg::MAX_PAT) : s_pattern_len;
        plen_eff = is_byte_op ? 4'd1 : plen_sat;
        src_pat  = is_byte_op ? {{(brbs_pkg::PAT_W-BW){1'b0}}, s_data_byte} : s_pattern;
    end

    // Reverse the active pattern bytes so that entry m lines up with the
    // m-th most recent byte of the window; both scan directions then use
    // the same compare.
    always_comb begin
        logic [PW-1:0] rev_idx;
        rev_idx = '0;
        rpat_in = '0;
        for (int m = 0; m < brbs_pkg::MAX_PAT; m++) begin
            rev_idx = plen_eff - 4'd1 - PW'(m);
            if (plen_eff > PW'(m)) begin
                rpat_in[m*BW +: BW] = src_pat[{rev_idx[2:0], 3'b000} +: BW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte store: one write port, one registered read port
    // ------------------------------------------------------------------
    assign mem_we  = acc && do_push && (cnt_reg < cap_reg);
    assign mem_re  = (state_reg == ST_SCAN) ? (left_reg != '0)
                                            : (acc && do_pop && (cnt_reg != '0));
    assign rd_addr = (state_reg == ST_SCAN) ? scan_addr_reg : old_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[nf_reg] <= s_data_byte;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Match window
    // ------------------------------------------------------------------
    assign win_ctl.clear = acc;
    assign win_ctl.shift = rd_vld_reg;

    brbs_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .byte_in (mem_rd_reg),
        .rpat    (rpat_reg),
        .plen    (plen_reg),
        .hit     (win_hit)
    );

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        logic [AW-1:0] cnt_after;

        state_next     = state_reg;
        cap_next       = cap_reg;
        old_next       = old_reg;
        nf_next        = nf_reg;
        cnt_next       = cnt_reg;
        scan_addr_next = scan_addr_reg;
        scan_off_next  = scan_off_reg;
        left_next      = left_reg;
        fwd_next       = fwd_reg;
        plen_next      = plen_reg;
        rpat_next      = rpat_reg;
        rd_vld_next    = 1'b0;
        rd_off_next    = rd_off_reg;
        rd_last_next   = rd_last_reg;
        ok_next        = ok_reg;
        pop_next       = pop_reg;
        moff_next      = moff_reg;
        fill_next      = fill_reg;
        empty_next     = empty_reg;
        full_next      = full_reg;
        cnt_after      = cnt_reg;

        // drop the result once it is taken
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    m_valid_next = 1'b1;
                    ok_next      = 1'b0;
                    pop_next     = 1'b0;
                    moff_next    = '0;
                    if (do_push && (cnt_reg < cap_reg)) begin
                        // advance the write pointer with wrap at the ring end
                        nf_next   = (nf_reg == cap_reg) ? '0 : nf_reg + 8'd1;
                        cnt_after = cnt_reg + 8'd1;
                        ok_next   = 1'b1;
                    end
                    if (do_pop && (cnt_reg != '0)) begin
                        // byte arrives in mem_rd_reg at the same edge
                        old_next  = (old_reg == cap_reg) ? '0 : old_reg + 8'd1;
                        cnt_after = cnt_reg - 8'd1;
                        ok_next   = 1'b1;
                        pop_next  = 1'b1;
                    end
                    if (do_search && (cnt_reg != '0) && (plen_eff != '0)) begin
                        // hold the result until the walk finishes
                        m_valid_next = 1'b0;
                        state_next   = ST_SCAN;
                        fwd_next     = search_fwd;
                        plen_next    = plen_eff;
                        rpat_next    = rpat_in;
                        left_next    = cnt_reg;
                        if (search_fwd) begin
                            scan_addr_next = old_reg;
                            scan_off_next  = '0;
                        end else begin
                            scan_addr_next = (nf_reg == '0) ? cap_reg : nf_reg - 8'd1;
                            scan_off_next  = cnt_reg - 8'd1;
                        end
                    end
                    cnt_next   = cnt_after;
                    fill_next  = cnt_after;
                    empty_next = (cnt_after == '0);
                    full_next  = (cnt_after == cap_reg);
                end
            end
            ST_SCAN: begin
                // issue one read per cycle
                if (left_reg != '0) begin
                    rd_vld_next  = 1'b1;
                    rd_off_next  = scan_off_reg;
                    rd_last_next = (left_reg == 8'd1);
                    left_next    = left_reg - 8'd1;
                    if (fwd_reg) begin
                        scan_addr_next = (scan_addr_reg == cap_reg) ? '0
                                                                    : scan_addr_reg + 8'd1;
                        scan_off_next  = scan_off_reg + 8'd1;
                    end else begin
                        scan_addr_next = (scan_addr_reg == '0) ? cap_reg
                                                               : scan_addr_reg - 8'd1;
                        scan_off_next  = scan_off_reg - 8'd1;
                    end
                end
                // first hit, or the last byte without one, ends the walk
                if (rd_vld_reg && (win_hit || rd_last_reg)) begin
                    state_next   = ST_IDLE;
                    rd_vld_next  = 1'b0;
                    left_next    = '0;
                    m_valid_next = 1'b1;
                    ok_next      = win_hit;
                    pop_next     = 1'b0;
                    if (!win_hit) begin
                        moff_next = '0;
                    end else if (fwd_reg) begin
                        moff_next = rd_off_reg - {4'd0, plen_reg - 4'd1};
                    end else begin
                        moff_next = rd_off_reg + {4'd0, plen_reg - 4'd1};
                    end
                    fill_next  = cnt_reg;
                    empty_next = (cnt_reg == '0);
                    full_next  = (cnt_reg == cap_reg);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the buffer
        if (cfg_we) begin
            cap_next = cfg_wdata;
            old_next = '0;
            nf_next  = '0;
            cnt_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= 8'd255;
            old_reg     <= '0;
            nf_reg      <= '0;
            cnt_reg     <= '0;
            left_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            old_reg     <= old_next;
            nf_reg      <= nf_next;
            cnt_reg     <= cnt_next;
            left_reg    <= left_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        scan_off_reg  <= scan_off_next;
        fwd_reg       <= fwd_next;
        plen_reg      <= plen_next;
        rpat_reg      <= rpat_next;
        rd_off_reg    <= rd_off_next;
        rd_last_reg   <= rd_last_next;
        ok_reg        <= ok_next;
        pop_reg       <= pop_next;
        moff_reg      <= moff_next;
        fill_reg      <= fill_next;
        empty_reg     <= empty_next;
        full_reg      <= full_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_valid        = m_valid_reg;
    assign m_ok           = ok_reg;
    assign m_data_out     = pop_reg ? mem_rd_reg : '0;
    assign m_match_offset = moff_reg;
    assign m_fill_count   = fill_reg;
    assign m_is_empty     = empty_reg;
    assign m_is_full      = full_reg;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ============================================================================
// tb - self-checking testbench for byte_ring_buffer_with_search
// Drives push, pop and search requests through the valid/ready request port
// under random bursts and result stalls. A shadow ring predicts each result,
// and every returned result is checked field by field against it.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // codes six and seven have no operation behind them
    localparam logic [brbs_pkg::FUNC_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [brbs_pkg::FUNC_W-1:0] FN_RSVD7 = 3'd7;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;   // long result stall for the backpressure test
    localparam int DRAIN_CYCLES = 300;   // a full-ring search plus margin

    typedef struct packed {
        logic                         ok;
        logic [brbs_pkg::BYTE_W-1:0]  data_out;
        logic [brbs_pkg::BYTE_W-1:0]  match_offset;
        logic [brbs_pkg::BYTE_W-1:0]  fill_count;
        logic                         is_empty;
        logic                         is_full;
    } ring_result_t;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    logic [7:0]                   cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    logic [brbs_pkg::FUNC_W-1:0]  s_func;
    logic [brbs_pkg::BYTE_W-1:0]  s_data_byte;
    logic [brbs_pkg::PAT_W-1:0]   s_pattern;
    logic [brbs_pkg::PLEN_W-1:0]  s_pattern_len;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_ok;
    logic [7:0]                   m_data_out;
    logic [7:0]                   m_match_offset;
    logic [7:0]                   m_fill_count;
    logic                         m_is_empty;
    logic                         m_is_full;

    byte_ring_buffer_with_search u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_data_byte    (s_data_byte),
        .s_pattern      (s_pattern),
        .s_pattern_len  (s_pattern_len),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_data_out     (m_data_out),
        .m_match_offset (m_match_offset),
        .m_fill_count   (m_fill_count),
        .m_is_empty     (m_is_empty),
        .m_is_full      (m_is_full)
    );

    // ------------------------------------------------------------------------
    // Shadow ring: contents, indices and capacity as the block should hold them
    // ------------------------------------------------------------------------
    logic [brbs_pkg::BYTE_W-1:0]  shadow_mem [0:brbs_pkg::SLOTS-1];
    int                           shadow_head;    // oldest byte
    int                           shadow_tail;    // next free slot
    logic [7:0]                   shadow_cap;

    ring_result_t       expected_results [$];
    int                 error_count;
    int                 results_seen;
    int                 cycle_count;
    int                 burst_left;
    int                 hold_token;     // bump to ask the sink for a long hold

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int ring_slots();
        return int'(shadow_cap) + 1;
    endfunction

    function automatic int fill_level();
        return (shadow_tail + ring_slots() - shadow_head) % ring_slots();
    endfunction

    // byte at a given distance from the oldest one
    function automatic logic [brbs_pkg::BYTE_W-1:0] held_byte(input int offset);
        return shadow_mem[(shadow_head + offset) % ring_slots()];
    endfunction

    // Apply one request to the shadow ring and return the result it must give.
    function automatic ring_result_t apply_request(
        input logic [brbs_pkg::FUNC_W-1:0] fn,
        input logic [brbs_pkg::BYTE_W-1:0] db,
        input logic [brbs_pkg::PAT_W-1:0]  pat,
        input logic [brbs_pkg::PLEN_W-1:0] plen_in);
        ring_result_t r;
        int ring, usable, held, plen, i, k;
        bit hit;
        ring   = ring_slots();
        usable = ring - 1;
        held   = fill_level();
        // lengths beyond the window saturate
        plen   = (plen_in > brbs_pkg::MAX_PAT) ? brbs_pkg::MAX_PAT : int'(plen_in);
        r      = '0;
        case (fn)
            brbs_pkg::FN_PUSH: begin
                if (held < usable) begin
                    shadow_mem[shadow_tail] = db;
                    shadow_tail = (shadow_tail + 1) % ring;
                    r.ok = 1'b1;
                end
            end
            brbs_pkg::FN_POP: begin
                if (held > 0) begin
                    r.data_out  = shadow_mem[shadow_head];
                    shadow_head = (shadow_head + 1) % ring;
                    r.ok = 1'b1;
                end
            end
            brbs_pkg::FN_BFWD: begin
                for (i = 0; i < held && !r.ok; i++) begin
                    if (held_byte(i) == db) begin
                        r.ok = 1'b1;
                        r.match_offset = 8'(i);
                    end
                end
            end
            brbs_pkg::FN_BBWD: begin
                for (i = held - 1; i >= 0 && !r.ok; i--) begin
                    if (held_byte(i) == db) begin
                        r.ok = 1'b1;
                        r.match_offset = 8'(i);
                    end
                end
            end
            brbs_pkg::FN_PFWD: begin
                // the whole pattern must lie inside the held bytes
                for (i = 0; plen > 0 && i + plen <= held && !r.ok; i++) begin
                    hit = 1'b1;
                    for (k = 0; k < plen; k++) begin
                        if (held_byte(i + k) != pat[8*k +: 8]) hit = 1'b0;
                    end
                    if (hit) begin
                        r.ok = 1'b1;
                        r.match_offset = 8'(i);
                    end
                end
            end
            brbs_pkg::FN_PBWD: begin
                // pattern byte k sits k places toward the oldest byte
                for (i = held - 1; plen > 0 && i >= plen - 1 && !r.ok; i--) begin
                    hit = 1'b1;
                    for (k = 0; k < plen; k++) begin
                        if (held_byte(i - k) != pat[8*k +: 8]) hit = 1'b0;
                    end
                    if (hit) begin
                        r.ok = 1'b1;
                        r.match_offset = 8'(i);
                    end
                end
            end
            default: begin
            end
        endcase
        held         = fill_level();
        r.fill_count = 8'(held);
        r.is_empty   = (held == 0);
        r.is_full    = (held == usable);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h, expected %0h",
                 results_seen, field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : result_check
        ring_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unrequested result", {63'd0, m_valid}, 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_ok !== want.ok)
                    report_mismatch("ok", 64'(m_ok), 64'(want.ok));
                if (m_data_out !== want.data_out)
                    report_mismatch("data_out", 64'(m_data_out), 64'(want.data_out));
                if (m_match_offset !== want.match_offset)
                    report_mismatch("match_offset", 64'(m_match_offset),
                                    64'(want.match_offset));
                if (m_fill_count !== want.fill_count)
                    report_mismatch("fill_count", 64'(m_fill_count),
                                    64'(want.fill_count));
                if (m_is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(m_is_empty), 64'(want.is_empty));
                if (m_is_full !== want.is_full)
                    report_mismatch("is_full", 64'(m_is_full), 64'(want.is_full));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: stall on a changing pattern; hold off for a long stretch
    // whenever a test asks for it
    // ------------------------------------------------------------------------
    initial begin : result_sink
        sink_mode_e mode;
        int         mode_left;
        int         hold_count;
        int         hold_served;
        m_ready     = 1'b0;
        mode        = SINK_OPEN;
        mode_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_token != hold_served) begin
                hold_served = hold_token;
                m_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one request, wait for its handshake and record the prediction.
    // Valid stays high across a burst; at the end of a burst mostly drop it for a gap.
    task automatic send_request(input logic [brbs_pkg::FUNC_W-1:0] fn,
                                input logic [brbs_pkg::BYTE_W-1:0] db,
                                input logic [brbs_pkg::PAT_W-1:0]  pat,
                                input logic [brbs_pkg::PLEN_W-1:0] plen);
        int gap;
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_data_byte   <= db;
        s_pattern     <= pat;
        s_pattern_len <= plen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(apply_request(fn, db, pat, plen));
        burst_left--;
        if (burst_left <= 0) begin
            // mostly short bursts, now and then a long unbroken run
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic sender_idle();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Write the capacity register with the block idle; the write empties the ring.
    task automatic write_capacity(input logic [7:0] value);
        sender_idle();
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        shadow_cap  = value;
        shadow_head = 0;
        shadow_tail = 0;
    endtask

    // One random request. Searches mostly take their byte or pattern from the
    // ring itself so that hits are common; the rest is random noise.
    task automatic random_request(input int push_w, input int pop_w, input bit narrow);
        int                           held, pick, off, len, k;
        logic [brbs_pkg::FUNC_W-1:0]  fn;
        logic [brbs_pkg::BYTE_W-1:0]  db;
        logic [brbs_pkg::PAT_W-1:0]   pat;
        logic [brbs_pkg::PLEN_W-1:0]  plen;
        held = fill_level();
        db   = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        pat  = {$urandom, $urandom};
        plen = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < push_w) begin
            fn = brbs_pkg::FN_PUSH;
        end else if (pick < push_w + pop_w) begin
            fn = brbs_pkg::FN_POP;
        end else if (pick < 98) begin
            case ($urandom_range(0, 3))
                0:       fn = brbs_pkg::FN_BFWD;
                1:       fn = brbs_pkg::FN_BBWD;
                2:       fn = brbs_pkg::FN_PFWD;
                default: fn = brbs_pkg::FN_PBWD;
            endcase
            if (held > 0 && $urandom_range(0, 3) != 0) begin
                off = $urandom_range(0, held - 1);
                db  = held_byte(off);
                if (fn == brbs_pkg::FN_PFWD) begin
                    len = $urandom_range(1, (held - off > brbs_pkg::MAX_PAT) ?
                                            brbs_pkg::MAX_PAT : held - off);
                    for (k = 0; k < len; k++) pat[8*k +: 8] = held_byte(off + k);
                    plen = 4'(len);
                end else if (fn == brbs_pkg::FN_PBWD) begin
                    len = $urandom_range(1, (off + 1 > brbs_pkg::MAX_PAT) ?
                                            brbs_pkg::MAX_PAT : off + 1);
                    for (k = 0; k < len; k++) pat[8*k +: 8] = held_byte(off - k);
                    plen = 4'(len);
                end
                // spoil one pattern byte now and then
                if ((fn == brbs_pkg::FN_PFWD || fn == brbs_pkg::FN_PBWD) &&
                    $urandom_range(0, 7) == 0)
                    pat[8*$urandom_range(0, len - 1) +: 8] ^= 8'(1 << $urandom_range(0, 7));
            end
        end else begin
            fn = $urandom_range(0, 1) ? FN_RSVD6 : FN_RSVD7;
        end
        send_request(fn, db, pat, plen);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Refused pop, searches with nothing held, and the unused codes.
    task automatic test_empty_buffer();
        send_request(brbs_pkg::FN_POP,  8'h00, 64'd0, 4'd1);
        send_request(brbs_pkg::FN_BFWD, 8'h00, 64'd0, 4'd1);
        send_request(brbs_pkg::FN_PBWD, 8'hFF, {brbs_pkg::PAT_W{1'b1}}, 4'd8);
        send_request(FN_RSVD6, 8'hFF, {brbs_pkg::PAT_W{1'b1}}, 4'hF);
        send_request(FN_RSVD7, 8'h00, 64'd0, 4'd0);
    endtask

    // Byte and pattern searches on a known short ring, including a zero
    // length, a saturated length and a pattern cut off at the newest byte.
    task automatic test_search_ops();
        send_request(brbs_pkg::FN_PUSH, 8'h00, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PUSH, 8'hFF, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PUSH, 8'h5A, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PUSH, 8'hFF, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PUSH, 8'h00, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PUSH, 8'h5A, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_BFWD, 8'hFF, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_BBWD, 8'hFF, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_BBWD, 8'h77, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PFWD, 8'h00, 64'hDEAD_BEEF_C0DE_5AFF, 4'd2);
        send_request(brbs_pkg::FN_PBWD, 8'h00, 64'hDEAD_BEEF_C0DE_005A, 4'd2);
        send_request(brbs_pkg::FN_PFWD, 8'h00, 64'h0000_0000_0000_00FF, 4'd0);
        send_request(brbs_pkg::FN_PFWD, 8'h00, {brbs_pkg::PAT_W{1'b1}}, 4'hF);
        send_request(brbs_pkg::FN_PFWD, 8'h00, 64'h0000_0000_0011_5A00, 4'd3);
        send_request(brbs_pkg::FN_PBWD, 8'h00, 64'h0000_00FF_5AFF_005A, 4'd6);
        send_request(brbs_pkg::FN_POP,  8'h00, 64'd0, 4'd0);
    endtask

    // Smallest capacities: a single usable byte, then none at all.
    task automatic test_capacity_limits();
        write_capacity(8'd1);
        send_request(brbs_pkg::FN_PUSH, 8'hFF, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PUSH, 8'h00, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_BBWD, 8'hFF, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_POP,  8'h00, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_POP,  8'h00, 64'd0, 4'd0);
        // capacity zero: always empty and full at once
        write_capacity(8'd0);
        send_request(brbs_pkg::FN_PUSH, 8'h3C, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_POP,  8'h00, 64'd0, 4'd0);
        send_request(brbs_pkg::FN_PBWD, 8'h00, 64'd0, 4'd1);
    endtask

    // Hold the sink off while requests keep coming, so the block backs up
    // and stalls its request port.
    task automatic test_input_backpressure();
        int n;
        write_capacity(8'd24);
        hold_token++;
        for (n = 0; n < 40; n++) random_request(75, 10, 1'b0);
    endtask

    // Random mixes over a spread of small and medium capacities.
    task automatic test_random_small_caps();
        int ph, n, push_w, pop_w;
        bit narrow;
        logic [7:0] cap;
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       cap = 8'd1;
                1:       cap = 8'd2;
                2:       cap = 8'd3;
                3:       cap = 8'($urandom_range(4, 12));
                4:       cap = 8'($urandom_range(13, 40));
                5:       cap = 8'd7;
                default: cap = 8'($urandom_range(41, 100));
            endcase
            write_capacity(cap);
            narrow = 1'($urandom_range(0, 1));
            push_w = 40;
            pop_w  = 40;
            for (n = 0; n < 26; n++) begin
                // change the fill trend every dozen requests
                if (n % 12 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       begin push_w = 70; pop_w = 15; end
                        1:       begin push_w = 20; pop_w = 65; end
                        default: begin push_w = 40; pop_w = 40; end
                    endcase
                end
                random_request(push_w, pop_w, narrow);
            end
        end
    endtask

    // Largest capacity: fill to the top, work near full, then drain.
    task automatic test_fill_to_max();
        int n;
        write_capacity(8'd255);
        for (n = 0; n < 300; n++) random_request(92, 2, n < 150);
        for (n = 0; n < 40;  n++) random_request(45, 45, 1'b0);
        for (n = 0; n < 60;  n++) random_request(5, 85, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'd0;
        s_valid       = 1'b0;
        s_func        = brbs_pkg::FN_PUSH;
        s_data_byte   = '0;
        s_pattern     = '0;
        s_pattern_len = '0;
        error_count   = 0;
        results_seen  = 0;
        burst_left    = 0;
        hold_token    = 0;
        shadow_cap    = 8'd255;
        shadow_head   = 0;
        shadow_tail   = 0;
        for (int j = 0; j < brbs_pkg::SLOTS; j++) shadow_mem[j] = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_buffer();
        test_search_ops();
        test_capacity_limits();
        test_input_backpressure();
        test_random_small_caps();
        test_fill_to_max();

        // release the request port, collect what is left, then watch for strays
        sender_idle();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### byte_ring_buffer_with_search.f
src/brbs_pkg.sv
src/brbs_window.sv
src/byte_ring_buffer_with_search.sv
tb/sv/tb.sv
